// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the checksum RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/tphc_pkg.sv =====
`timescale 1ns / 1ps

package tphc_pkg;

	// Default width of the byte counter
	localparam int LENGTH_BITS_DEF = 17;

	// Protocol byte after reset (TCP)
	localparam logic [7:0] PROTO_RESET = 8'd6;

	// Byte count codes of an input word
	localparam logic [1:0] BC_NONE = 2'd0;
	localparam logic [1:0] BC_ONE  = 2'd1;

	// Largest value a folded running sum can take
	localparam logic [16:0] SUM_MAX = 17'h10000;

	// Word handed from the input stages to the accumulator
	typedef struct packed {
		logic [15:0] data_word;
		logic [1:0]  byte_count;
		logic        first;
		logic        last;
		logic        include_pseudo;
		logic [16:0] pseudo_sum;
	} tphc_item_t;

	// Ones' complement add with one end-around fold; acc stays <= 0x10000
	function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] v);
		logic [17:0] s;
		s = {1'b0, acc} + {2'b00, v};
		return {1'b0, s[15:0]} + {15'b0, s[17:16]};
	endfunction

endpackage

// ===== sv/tcp_pseudo_header_checksum.sv =====
`timescale 1ns / 1ps
// A last word passes the input and second stage before its checksum is registered.
// Throughput: one input word per cycle unless a waiting result holds a last word back.
// Pipeline: input register, pseudo-header sum register, accumulator with output register.
// A waiting result stalls the pipeline only when the next last word reaches the accumulator.
// Reset (arst_n low, asynchronous): pipeline empty, sum and length cleared, protocol = 6.

`include "assert_macros.svh"

module tcp_pseudo_header_checksum #(
	parameter int LENGTH_BITS = tphc_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // data_word[15:0], byte_count[17:16],
	                                   // src_addr[49:18], dst_addr[81:50], zero[87:82]
	input  logic        s_axis_tlast,  // last
	input  logic [1:0]  s_axis_tuser,  // first[0], include_pseudo[1]
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // checksum[15:0]
	// Protocol register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // protocol_number
);
	import tphc_pkg::*;

	logic [7:0]  proto_q;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic [1:0]  count_s1;
	logic        first_s1;
	logic        last_s1;
	logic        pseudo_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;

	logic        valid_s2;
	tphc_item_t  item_s2;

	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic        out_free;
	logic        fire_s2;
	logic        free_s2;
	logic        move_s1;
	logic        take;
	logic [18:0] psum_wide;
	logic [16:0] psum_fold;
	logic [16:0] psum;
	logic [15:0] checksum;

	// Handshake
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire_s2       = valid_s2 && (!item_s2.last || out_free);
	assign free_s2       = !valid_s2 || fire_s2;
	assign move_s1       = valid_s1 && free_s2;
	assign s_axis_tready = !valid_s1 || free_s2;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Protocol register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q <= PROTO_RESET;
		end else if (cfg_valid) begin
			proto_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1   <= s_axis_tdata[15:0];
			count_s1  <= s_axis_tdata[17:16];
			src_s1    <= s_axis_tdata[49:18];
			dst_s1    <= s_axis_tdata[81:50];
			first_s1  <= s_axis_tuser[0];
			pseudo_s1 <= s_axis_tuser[1];
			last_s1   <= s_axis_tlast;
		end
	end

	// Pseudo-header sum: addresses and protocol added as a tree, then folded twice
	always_comb begin
		psum_wide = '0;
		if (pseudo_s1) begin
			psum_wide = ({3'b000, src_s1[31:16]} + {3'b000, src_s1[15:0]})
				+ ({3'b000, dst_s1[31:16]} + {3'b000, dst_s1[15:0]})
				+ {11'b0, proto_q};
		end
		psum_fold = {1'b0, psum_wide[15:0]} + {14'b0, psum_wide[18:16]};
		psum      = {1'b0, psum_fold[15:0]} + {16'b0, psum_fold[16]};
	end

	// Second stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (fire_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			item_s2.data_word      <= word_s1;
			item_s2.byte_count     <= count_s1;
			item_s2.first          <= first_s1;
			item_s2.last           <= last_s1;
			item_s2.include_pseudo <= pseudo_s1;
			item_s2.pseudo_sum     <= psum;
		end
	end

	tphc_accum #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (fire_s2),
		.item     (item_s2),
		.checksum (checksum)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s2 && item_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2 && item_s2.last) begin
			out_data_q <= checksum;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`ASSERT_NEXT(a_last_gives_result, fire_s2 && item_s2.last, out_valid_q)
	`ASSERT_IMPL(a_no_overwrite, out_valid_q && !m_axis_tready, !(fire_s2 && item_s2.last))
	`ASSERT_NEXT(a_nonlast_drains, valid_s2 && !item_s2.last, !valid_s2 || $past(move_s1))

endmodule

// ===== sv/tphc_accum.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tphc_accum #(
	parameter int LENGTH_BITS = tphc_pkg::LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  tphc_pkg::tphc_item_t  item,
	output logic [15:0]           checksum
);
	import tphc_pkg::*;

	logic [16:0]            sum_q;
	logic [LENGTH_BITS-1:0] total_q;
	logic                   pseudo_q;

	logic [16:0]            sum_base;
	logic [16:0]            sum_data;
	logic [16:0]            sum_len;
	logic [16:0]            sum_final;
	logic                   pseudo_cur;
	logic [LENGTH_BITS-1:0] total_base;
	logic [1:0]             nbytes;
	logic [LENGTH_BITS:0]   total_sum;
	logic [LENGTH_BITS-1:0] total_new;
	logic [LENGTH_BITS+15:0] total_ext;

	// A first word restarts from the precomputed pseudo-header sum
	always_comb begin
		sum_base   = item.first ? item.pseudo_sum : sum_q;
		pseudo_cur = item.first ? item.include_pseudo : pseudo_q;
		total_base = item.first ? '0 : total_q;
	end

	// Data word add; a single byte is padded with a zero low byte
	always_comb begin
		case (item.byte_count)
			BC_NONE: begin
				sum_data = sum_base;
				nbytes   = 2'd0;
			end
			BC_ONE: begin
				sum_data = fold_add(sum_base, {item.data_word[15:8], 8'h00});
				nbytes   = 2'd1;
			end
			default: begin
				sum_data = fold_add(sum_base, item.data_word);
				nbytes   = 2'd2;
			end
		endcase
	end

	// Saturating byte counter
	always_comb begin
		total_sum = {1'b0, total_base} + {{(LENGTH_BITS-1){1'b0}}, nbytes};
		total_new = total_sum[LENGTH_BITS] ? '1 : total_sum[LENGTH_BITS-1:0];
		total_ext = {16'b0, total_new};
	end

	// Segment length, last fold and inversion
	always_comb begin
		sum_len   = pseudo_cur ? fold_add(sum_data, total_ext[15:0]) : sum_data;
		sum_final = {1'b0, sum_len[15:0]} + {16'b0, sum_len[16]};
		checksum  = ~sum_final[15:0];
	end

	// Packet state; cleared after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			total_q  <= '0;
			pseudo_q <= 1'b0;
		end else if (step) begin
			if (item.last) begin
				sum_q    <= '0;
				total_q  <= '0;
				pseudo_q <= 1'b0;
			end else begin
				sum_q    <= sum_data;
				total_q  <= total_new;
				pseudo_q <= pseudo_cur;
			end
		end
	end

	`ASSERT_IMPL(a_sum_bound, 1'b1, sum_q <= SUM_MAX)
	`ASSERT_NEXT(a_clear_after_last, step && item.last, sum_q == '0 && total_q == '0 && !pseudo_q)
	`ASSERT_NEXT(a_total_grows, step && !item.first && !item.last, total_q >= $past(total_q))

endmodule

// ===== bench/tcp_pseudo_header_checksum_tb.sv =====
`timescale 1ns / 1ps

module tcp_pseudo_header_checksum_tb;

	localparam int LEN_BITS = tphc_pkg::LENGTH_BITS_DEF;
	localparam int LEN_MAX = (1 << LEN_BITS) - 1;
	localparam logic [1:0] BC_TWO = 2'd2;
	localparam logic [1:0] BC_THREE = 2'd3;
	localparam int STALL_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	// One stream word as the sender sees it
	typedef struct {
		logic [15:0] data;
		logic [1:0]  count;
		bit          first;
		bit          last;
		bit          pseudo;
		logic [31:0] src;
		logic [31:0] dst;
	} stream_word_t;

	// Predicts checksums from accepted words and checks the result stream
	class checksum_scoreboard;
		logic [7:0]          protocol;
		logic [16:0]         sum;
		logic [LEN_BITS-1:0] byte_total;
		bit                  pseudo_on;
		logic [15:0]         checksums_due[$];
		int                  errors;

		function new();
			protocol = tphc_pkg::PROTO_RESET;
			sum = '0;
			byte_total = '0;
			pseudo_on = 0;
			errors = 0;
		endfunction

		// End-around add; result never exceeds 0x10000
		function logic [16:0] ones_add(logic [16:0] acc, logic [15:0] v);
			logic [31:0] s;
			s = 32'(acc) + 32'(v);
			return 17'((s & 32'h0000ffff) + (s >> 16));
		endfunction

		function void note_word(stream_word_t w);
			int total;
			int nbytes;
			if (w.first) begin
				sum = '0;
				byte_total = '0;
				pseudo_on = w.pseudo;
				if (w.pseudo) begin
					sum = ones_add(sum, w.src[31:16]);
					sum = ones_add(sum, w.src[15:0]);
					sum = ones_add(sum, w.dst[31:16]);
					sum = ones_add(sum, w.dst[15:0]);
					sum = ones_add(sum, {8'h00, protocol});
				end
			end
			nbytes = 0;
			// odd byte: low half is padded with zero wherever it falls
			if (w.count == tphc_pkg::BC_ONE) begin
				sum = ones_add(sum, {w.data[15:8], 8'h00});
				nbytes = 1;
			end else if (w.count != tphc_pkg::BC_NONE) begin
				sum = ones_add(sum, w.data);
				nbytes = 2;
			end
			// length counter saturates
			total = int'(byte_total) + nbytes;
			if (total > LEN_MAX)
				byte_total = '1;
			else
				byte_total = LEN_BITS'(total);
			if (w.last) begin
				if (pseudo_on)
					sum = ones_add(sum, byte_total[15:0]);
				sum = {1'b0, sum[15:0]} + {16'b0, sum[16]};
				checksums_due.push_back(~sum[15:0]);
				sum = '0;
				byte_total = '0;
				pseudo_on = 0;
			end
		endfunction

		function void check_checksum(logic [15:0] got);
			logic [15:0] want;
			if (checksums_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("checksum %h arrived with none expected", got);
			end else begin
				want = checksums_due.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("checksum mismatch: expected %h, got %h", want, got);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	checksum_scoreboard sb = new();

	int send_idle;
	int recv_idle;
	bit stall_request;
	int stall_left;
	int idle_cycles;
	int items_sent;

	tcp_pseudo_header_checksum u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random ready, or a long hold-off when asked
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_left = STALL_CYCLES;
				stall_request = 0;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// Outputs are sampled mid-cycle; a handshake seen here completes at the next edge
	always @(negedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_checksum(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL tcp_pseudo_header_checksum");
				$finish;
			end
		end
	end

	function automatic stream_word_t mk_word(logic [15:0] data, logic [1:0] count,
			bit first, bit last, bit pseudo, logic [31:0] src, logic [31:0] dst);
		stream_word_t w;
		w.data = data;
		w.count = count;
		w.first = first;
		w.last = last;
		w.pseudo = pseudo;
		w.src = src;
		w.dst = dst;
		return w;
	endfunction

	task automatic send_word(stream_word_t w);
		bit taken;
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, w.dst, w.src, w.count, w.data};
		s_axis_tlast <= w.last;
		s_axis_tuser <= {w.pseudo, w.first};
		forever begin
			@(negedge clk);
			taken = s_axis_tready;
			if (taken)
				sb.note_word(w);
			@(posedge clk);
			if (taken)
				break;
		end
	endtask

	// Well-formed packet with random content; odd bytes mostly on the last word
	task automatic send_packet(int n_words, bit long_run);
		stream_word_t w;
		bit pseudo;
		logic [31:0] src;
		logic [31:0] dst;
		int r;
		pseudo = long_run || ($urandom_range(0, 3) != 0);
		src = $urandom;
		dst = $urandom;
		for (int i = 0; i < n_words; i++) begin
			w.data = 16'($urandom);
			w.first = (i == 0);
			w.last = (i == n_words - 1);
			w.pseudo = (i == 0) ? pseudo : 1'($urandom_range(0, 1));
			w.src = (i == 0) ? src : $urandom;
			w.dst = (i == 0) ? dst : $urandom;
			w.count = BC_TWO;
			r = $urandom_range(0, 99);
			if (w.last && r < 50)
				w.count = tphc_pkg::BC_ONE;
			else if (!long_run && r < 5)
				w.count = tphc_pkg::BC_ONE;
			else if (!long_run && r < 8)
				w.count = tphc_pkg::BC_NONE;
			else if (!long_run && r < 11)
				w.count = BC_THREE;
			send_word(w);
			items_sent++;
		end
	endtask

	// Any field combination, including stray first and last marks
	task automatic send_noise();
		send_word(mk_word(16'($urandom), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom));
		items_sent++;
	endtask

	task automatic run_random(int n_items);
		int r;
		int target;
		target = items_sent + n_items;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				send_noise();
			else if (r < 75)
				send_packet($urandom_range(1, 6), 0);
			else if (r < 95)
				send_packet($urandom_range(7, 20), 0);
			else
				send_packet($urandom_range(21, 60), 0);
		end
	endtask

	// Drop valid, let all checksums come back and the pipeline empty
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.checksums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_protocol(logic [7:0] value);
		bit taken;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		forever begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
			if (taken)
				break;
		end
		sb.protocol = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		stall_request = 0;
		stall_left = 0;
		items_sent = 0;
		send_idle = 36;
		recv_idle = 73;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words, protocol still at its reset value
		// single-word packets, all-ones and all-zeros
		send_word(mk_word(16'hffff, BC_TWO, 1, 1, 1, 32'hffffffff, 32'hffffffff));
		send_word(mk_word(16'h0000, BC_TWO, 1, 1, 0, 32'h00000000, 32'h00000000));
		send_word(mk_word(16'hffff, BC_TWO, 1, 1, 0, 32'hffffffff, 32'h00000000));
		// zero count, count three, odd byte in the middle, odd byte at the end
		send_word(mk_word(16'hffff, tphc_pkg::BC_NONE, 1, 0, 1, 32'h00000000, 32'hffffffff));
		send_word(mk_word(16'hffff, BC_THREE, 0, 0, 0, 32'hffffffff, 32'hffffffff));
		send_word(mk_word(16'h12ab, tphc_pkg::BC_ONE, 0, 0, 0, 32'h0, 32'h0));
		send_word(mk_word(16'hff00, tphc_pkg::BC_ONE, 0, 1, 1, 32'h0, 32'h0));
		// words with no first mark, then a bare last
		send_word(mk_word(16'h8001, BC_TWO, 0, 0, 1, 32'hc0a80001, 32'h0a000001));
		send_word(mk_word(16'h7ffe, BC_TWO, 0, 1, 0, 32'h0, 32'h0));
		// last word carrying no bytes
		send_word(mk_word(16'h4500, BC_TWO, 1, 0, 1, 32'hc0a80001, 32'hc0a800c7));
		send_word(mk_word(16'hffff, tphc_pkg::BC_NONE, 0, 1, 0, 32'h0, 32'h0));
		// second first mark restarts the packet
		send_word(mk_word(16'h1234, BC_TWO, 1, 0, 1, 32'hffffffff, 32'h0));
		send_word(mk_word(16'h5678, BC_TWO, 1, 0, 0, 32'h0, 32'hffffffff));
		send_word(mk_word(16'h00ff, tphc_pkg::BC_ONE, 0, 1, 1, 32'h0, 32'h0));
		items_sent += 14;

		write_protocol(8'hff);
		send_word(mk_word(16'h0000, BC_TWO, 1, 1, 1, 32'hffffffff, 32'hffffffff));
		items_sent++;
		run_random(140);
		// long hold-off on the result side while short packets keep coming
		stall_request = 1;
		repeat (40) send_packet($urandom_range(1, 2), 0);

		write_protocol(8'h00);
		send_idle = 73;
		recv_idle = 36;
		send_word(mk_word(16'hffff, BC_TWO, 1, 1, 1, 32'hffffffff, 32'hffffffff));
		items_sent++;
		run_random(140);

		write_protocol(8'($urandom_range(1, 254)));
		send_idle = 0;
		recv_idle = 0;
		// one long packet of full words (the last may hold an odd byte), back to back
		send_packet($urandom_range(40, 60), 1);
		run_random(140);

		wait_idle();
		if (sb.errors == 0)
			$display("PASS tcp_pseudo_header_checksum");
		else
			$display("FAIL tcp_pseudo_header_checksum");
		$finish;
	end

endmodule
